>>> rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and codes for the voice allocator: event codes, the scan
// token that walks the slot chain, and per-slot command and status beats
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int OP_W     = 2;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;
	localparam int DONE_W   = 5;
	localparam int SLOT_W   = 5;
	localparam int MASK_W   = 32;

	localparam logic [OP_W-1:0] OP_NOTE_ON    = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE_OFF   = 2'd1;
	localparam logic [OP_W-1:0] OP_VOICE_DONE = 2'd2;

	// scan token, handed from slot to slot once per cycle
	typedef struct packed {
		logic              valid;
		logic              off_done;    // an earlier slot already released this note
		logic              free_found;  // some earlier slot is free
		logic              rel_found;   // some earlier slot is releasing
		logic [MASK_W-1:0] mask;        // release bits gathered so far
	} tok_t;

	// write command to one slot
	typedef struct packed {
		logic set;  // claim: busy, new note, not releasing
		logic clr;  // free the slot
	} cmd_t;

	// what a slot saw when the token passed
	typedef struct packed {
		logic cand_free;  // first free slot of the chain
		logic cand_rel;   // first releasing slot of the chain
	} stat_t;

endpackage

>>> rtl/pva_cell.sv
// ----------------------------------------------------------------------------
// pva_cell
// one voice slot: busy mark, note, releasing mark; updates itself when the
// scan token passes and hands the token on to the next slot
// ----------------------------------------------------------------------------
module pva_cell #(
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pva_pkg::tok_t                  tok_in,
	output pva_pkg::tok_t                  tok_out,
	input  logic [pva_pkg::NOTE_W-1:0]     scan_note,
	input  logic                           scan_on,
	input  pva_pkg::cmd_t                  cmd,
	input  logic [pva_pkg::NOTE_W-1:0]     cmd_note,
	output pva_pkg::stat_t                 stat
);
	import pva_pkg::*;

	localparam logic [MASK_W-1:0] MY_BIT = (IDX < MASK_W) ? (MASK_W'(1) << IDX) : '0;

	logic              busy_q;
	logic              rel_q;
	logic [NOTE_W-1:0] note_q;
	logic              tok_vld_q;
	tok_t              tok_q;
	stat_t             stat_q;

	logic match;
	logic rel_now;
	logic rel_after;
	tok_t tok_next;

	always_comb begin
		match     = busy_q && !rel_q && (note_q == scan_note);
		rel_now   = match && (scan_on || !tok_in.off_done);
		rel_after = rel_q || rel_now;
		tok_next  = tok_in;
		tok_next.off_done   = tok_in.off_done || rel_now;
		tok_next.free_found = tok_in.free_found || !busy_q;
		tok_next.rel_found  = tok_in.rel_found || rel_after;
		tok_next.mask       = tok_in.mask | (rel_now ? MY_BIT : '0);
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rel_q  <= 1'b0;
		end else if (cmd.set) begin
			busy_q <= 1'b1;
			rel_q  <= 1'b0;
		end else if (cmd.clr) begin
			busy_q <= 1'b0;
			rel_q  <= 1'b0;
		end else if (tok_in.valid) begin
			rel_q <= rel_after;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set) begin
			note_q <= cmd_note;
		end
	end

	// token stage toward the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_q            <= tok_next;
			stat_q.cand_free <= !busy_q && !tok_in.free_found;
			stat_q.cand_rel  <= rel_after && !tok_in.rel_found;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_vld_q;
	end

	assign stat = stat_q;

endmodule

>>> rtl/polyphonic_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_core
// voice slot allocator with stealing, built as a chain of slot cells that a
// scan token walks once per note event
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             beat
// event     in         start & !busy         operation, note, velocity, done_slot
// result    out        strobe (one cycle)    assigned_valid, assigned_slot, stolen,
//                                            release_mask
//
// note on / note off: busy while the token is launched and walks one slot cell
//   per cycle; the commit is made as the token leaves the last slot
// voice finished and the unused code: busy only for the finish state, no scan
// every event gives one result beat, strobe high in the same cycle that busy drops
// reset clears every busy and releasing mark at once; no clearing pass
// the receiver cannot stall; a new event may be taken during the result beat
//
module polyphonic_voice_allocator_core #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pva_pkg::OP_W-1:0]          operation,
	input  logic [pva_pkg::NOTE_W-1:0]        note,
	input  logic [pva_pkg::VEL_W-1:0]         velocity,
	input  logic [pva_pkg::DONE_W-1:0]        done_slot,
	output logic                              strobe,
	output logic                              assigned_valid,
	output logic [pva_pkg::SLOT_W-1:0]        assigned_slot,
	output logic                              stolen,
	output logic [pva_pkg::MASK_W-1:0]        release_mask
);
	import pva_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	// wide enough for any slot index and for done_slot
	localparam int XW = IW + DONE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic              launch_q;
	logic              scan_on_q;
	logic [OP_W-1:0]   op_q;
	logic [NOTE_W-1:0] note_q;
	logic [DONE_W-1:0] done_q;

	// token chain; chain[0] feeds slot 0, chain[NUM_SLOTS] leaves the last slot
	tok_t              chain [NUM_SLOTS+1];
	cmd_t              cmd   [NUM_SLOTS];
	stat_t             stat  [NUM_SLOTS];

	logic [NUM_SLOTS-1:0] claim_vec;
	logic [NUM_SLOTS-1:0] clr_vec;
	logic [IW-1:0]        slot_idx;
	logic [XW-1:0]        slot_ext;
	logic [XW-1:0]        done_ext;
	logic                 scan_end;
	tok_t                 last_tok;

	assign busy = (state_q != ST_IDLE);

	// token launched into slot 0 the cycle after a note event is taken
	always_comb begin
		chain[0]            = '0;
		chain[0].valid      = launch_q;
	end

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
		pva_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (chain[i]),
			.tok_out   (chain[i+1]),
			.scan_note (note_q),
			.scan_on   (scan_on_q),
			.cmd       (cmd[i]),
			.cmd_note  (note_q),
			.stat      (stat[i])
		);
		assign cmd[i] = '{set: claim_vec[i], clr: clr_vec[i]};
	end

	assign last_tok = chain[NUM_SLOTS];
	assign scan_end = (state_q == ST_SCAN) && last_tok.valid;
	assign done_ext = XW'(done_q);

	// commit: pick the claimed slot once the token has seen every slot
	always_comb begin
		claim_vec = '0;
		clr_vec   = '0;
		if (scan_end && scan_on_q) begin
			if (last_tok.free_found) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					claim_vec[i] = stat[i].cand_free;
				end
			end else if (last_tok.rel_found) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					claim_vec[i] = stat[i].cand_rel;
				end
			end else begin
				// nothing free or releasing: steal slot 0
				claim_vec[0] = 1'b1;
			end
		end
		if ((state_q == ST_FINISH) && (op_q == OP_VOICE_DONE)) begin
			// out of range slots simply never match
			for (int i = 0; i < NUM_SLOTS; i++) begin
				clr_vec[i] = (done_ext == XW'(i));
			end
		end
	end

	// one-hot claim to slot number
	always_comb begin
		slot_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_idx = slot_idx | (claim_vec[i] ? IW'(i) : '0);
		end
		slot_ext = XW'(slot_idx);
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			launch_q       <= 1'b0;
			strobe         <= 1'b0;
			scan_on_q      <= 1'b0;
			op_q           <= OP_NOTE_ON;
			note_q         <= '0;
			done_q         <= '0;
			assigned_valid <= 1'b0;
			assigned_slot  <= '0;
			stolen         <= 1'b0;
			release_mask   <= '0;
		end else begin
			strobe   <= 1'b0;
			launch_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q      <= operation;
						note_q    <= note;
						done_q    <= done_slot;
						scan_on_q <= (operation == OP_NOTE_ON) && (velocity != '0);
						if ((operation == OP_NOTE_ON) || (operation == OP_NOTE_OFF)) begin
							launch_q <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							state_q  <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (last_tok.valid) begin
						strobe         <= 1'b1;
						assigned_valid <= scan_on_q;
						assigned_slot  <= scan_on_q ? slot_ext[SLOT_W-1:0] : '0;
						stolen         <= scan_on_q && !last_tok.free_found;
						release_mask   <= last_tok.mask;
						state_q        <= ST_IDLE;
					end
				end
				ST_FINISH: begin
					strobe         <= 1'b1;
					assigned_valid <= 1'b0;
					assigned_slot  <= '0;
					stolen         <= 1'b0;
					release_mask   <= '0;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// at most one slot claimed or freed per commit
	a_claim_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(claim_vec) && $onehot0(clr_vec))
		else $error("more than one slot written in one commit");

	// a note on always claims exactly one slot at the end of its scan
	a_claim_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_end && scan_on_q) |-> $onehot(claim_vec))
		else $error("note on scan ended without a claim");

	// the token leaves the chain only while a scan is under way
	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last_tok.valid |-> (state_q == ST_SCAN))
		else $error("scan token outside a scan");

	// a result beat follows the end of an event
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(scan_end) || $past(state_q == ST_FINISH)))
		else $error("result beat without a finished event");

	// stealing only happens on an assignment
	a_stolen_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && stolen) |-> assigned_valid)
		else $error("stolen set without an assigned slot");

endmodule
